[rtl/core/sha2_pkg.sv]
// Package for the SHA-224/SHA-256 hasher: round constants, initial values,
// a rotate function and the controller-to-datapath command and status types.
`default_nettype none
package sha2_pkg;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUT_BYTE,
        CMD_PUT_LEN,
        CMD_START,
        CMD_ROUND,
        CMD_FINISH,
        CMD_LOAD_IV
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [7:0] byte_val;
        logic       count_byte;
        logic [5:0] round_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } dp_status_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_value(input logic mode, input logic [2:0] idx);
        logic [31:0] v;
        case ({mode, idx})
            4'd0: v = 32'h6a09e667; 4'd1: v = 32'hbb67ae85;
            4'd2: v = 32'h3c6ef372; 4'd3: v = 32'ha54ff53a;
            4'd4: v = 32'h510e527f; 4'd5: v = 32'h9b05688c;
            4'd6: v = 32'h1f83d9ab; 4'd7: v = 32'h5be0cd19;
            4'd8: v = 32'hc1059ed8; 4'd9: v = 32'h367cd507;
            4'd10: v = 32'h3070dd17; 4'd11: v = 32'hf70e5939;
            4'd12: v = 32'hffc00b31; 4'd13: v = 32'h68581511;
            4'd14: v = 32'h64f98fa7; 4'd15: v = 32'hbefa4fa4;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

endpackage
`default_nettype wire

[rtl/core/sha2_datapath.sv]
// Datapath of the SHA-224/SHA-256 hasher: block buffer, message schedule,
// round registers, chaining value and bit counter. Depends on sha2_pkg.
`default_nettype none
module sha2_datapath
    import sha2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        mode,
    input  wire dp_cmd_t     cmd,
    output      dp_status_t  status,
    input  wire logic [2:0]  out_idx,
    output      logic [31:0] out_word
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [63:0] bit_count_reg;
    logic [5:0]  pos_reg;

    logic [5:0]  pos;
    logic [3:0]  wsel;
    logic [4:0]  shamt;
    logic [31:0] ins;
    logic [31:0] s0, s1, w_new, t1, t2;
    logic [31:0] a, b, c, e, f, g;

    // Block position advances on message and padding bytes alike.
    assign pos = pos_reg;
    assign status.pos = pos;
    assign wsel = pos[5:2];
    assign shamt = 5'(5'd24 - {pos[1:0], 3'b000});
    assign ins = {24'h0, cmd.byte_val} << shamt;
    assign out_word = h_reg[out_idx];

    // Schedule runs as a 16-word sliding window; w_reg[0] is this round's word.
    assign s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;

    assign a = v_reg[0]; assign b = v_reg[1]; assign c = v_reg[2];
    assign e = v_reg[4]; assign f = v_reg[5]; assign g = v_reg[6];
    assign t1 = v_reg[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
              + ((e & f) ^ (~e & g)) + round_k(cmd.round_idx) + w_reg[0];
    assign t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

    // Block buffer, schedule window and round variables.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_PUT_BYTE:
            begin
                if (pos[1:0] == 2'd0)
                    w_reg[wsel] <= ins;
                else
                    w_reg[wsel] <= w_reg[wsel] | ins;
            end
            CMD_PUT_LEN:
            begin
                w_reg[14] <= bit_count_reg[63:32];
                w_reg[15] <= bit_count_reg[31:0];
            end
            CMD_START:
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            CMD_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= w_new;
                v_reg[7] <= g; v_reg[6] <= f; v_reg[5] <= e;
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= c; v_reg[2] <= b; v_reg[1] <= a;
                v_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end

    // Chaining value, bit counter and block position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_value(1'b0, 3'(i));
            bit_count_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                CMD_PUT_BYTE:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (cmd.count_byte)
                        bit_count_reg <= bit_count_reg + 64'd8;
                end
                CMD_PUT_LEN:
                begin
                    pos_reg <= '0;
                end
                CMD_FINISH:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                end
                CMD_LOAD_IV:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= init_value(mode, 3'(i));
                    bit_count_reg <= '0;
                    pos_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/sha2_ctrl.sv]
// Controller of the SHA-224/SHA-256 hasher: input handshake, padding sequence,
// round counting and digest output. Depends on sha2_pkg.
`default_nettype none
module sha2_ctrl
    import sha2_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mode,
    input  wire logic       cfg_write,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic       in_has,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [2:0] out_idx,
    output      logic       out_last,
    output      dp_cmd_t    cmd,
    input  wire dp_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_START,
        S_ROUND,
        S_FIN,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       fin_reg, fin_next;
    logic       pad80_reg, pad80_next;
    logic       mode_reg, mode_next;
    logic       last_block_reg, last_block_next;
    logic       full;

    assign in_ready = (state_reg == S_IDLE) && !cfg_write;
    assign out_valid = (state_reg == S_OUT);
    assign out_idx = idx_reg;
    assign out_last = mode_reg ? (idx_reg == 3'd6) : (idx_reg == 3'd7);
    assign full = (status.pos == 6'd63);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        idx_next = idx_reg;
        fin_next = fin_reg;
        pad80_next = pad80_reg;
        mode_next = mode_reg;
        last_block_next = last_block_reg;
        cmd = '{op: CMD_NONE, byte_val: 8'h00, count_byte: 1'b0, round_idx: rnd_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_write)
                    cmd.op = CMD_LOAD_IV;
                else if (in_valid)
                begin
                    fin_next = in_last;
                    pad80_next = 1'b1;
                    if (in_has)
                    begin
                        cmd.op = CMD_PUT_BYTE;
                        cmd.byte_val = in_byte;
                        cmd.count_byte = 1'b1;
                        if (full)
                            state_next = S_START;
                        else if (in_last)
                            state_next = S_PAD;
                    end
                    else if (in_last)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                // The 0x80 marker, zeros up to byte 56, then the bit length.
                if (!pad80_reg && status.pos == 6'd56)
                begin
                    cmd.op = CMD_PUT_LEN;
                    fin_next = 1'b0;
                    last_block_next = 1'b1;
                    state_next = S_START;
                end
                else
                begin
                    cmd.op = CMD_PUT_BYTE;
                    cmd.byte_val = pad80_reg ? 8'h80 : 8'h00;
                    pad80_next = 1'b0;
                    if (full)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                // Copy the chaining value into the round registers.
                cmd.op = CMD_START;
                rnd_next = 6'd0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.op = CMD_ROUND;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = CMD_FINISH;
                if (fin_reg)
                    state_next = S_PAD;
                else if (last_block_reg)
                begin
                    state_next = S_OUT;
                    idx_next = 3'd0;
                    mode_next = mode;
                end
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (out_last)
                    begin
                        cmd.op = CMD_LOAD_IV;
                        last_block_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rnd_reg <= '0;
            idx_reg <= '0;
            fin_reg <= 1'b0;
            pad80_reg <= 1'b0;
            mode_reg <= 1'b0;
            last_block_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            idx_reg <= idx_next;
            fin_reg <= fin_next;
            pad80_reg <= pad80_next;
            mode_reg <= mode_next;
            last_block_reg <= last_block_next;
        end
    end

`ifndef SYNTH
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("output valid while input ready");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg <= 3'd7))
        else $error("digest index out of range");
    a_round_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && rnd_reg == 6'd63) |=> state_reg == S_FIN)
        else $error("round count did not end compression");
`endif

endmodule
`default_nettype wire

[rtl/core/sha224_sha256_hash.sv]
// SHA-224/SHA-256 hasher, one message byte per input word, digest words out.
// A full 64-byte block holds the input while it is compressed: the round
// registers are loaded, 64 rounds run at one per cycle on a single compression
// unit and the result is folded into the chaining value. The final item adds
// padding at one byte per cycle up to byte 56, then the bit length, one or two
// such compressions and the digest words at one per accepted output cycle.
// Depends on sha2_pkg, sha2_ctrl and sha2_datapath.
`default_nettype none
module sha224_sha256_hash
    import sha2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // message_byte
    input  wire logic        s_tuser,   // has_byte
    input  wire logic        s_tlast,   // end_of_message
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,   // digest_word, word_index, zero fill
    output      logic        m_tlast    // last_word
);

    logic       mode_reg;
    logic       cfg_write;
    logic [2:0] out_idx;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [31:0] out_word;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {31'h0, mode_reg} : 32'h0;
    assign m_tdata = {5'h0, out_idx, out_word};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_write)
            mode_reg <= pwdata[0];
    end

    sha2_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .mode(mode_reg), .cfg_write(cfg_write),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_has(s_tuser),
        .in_byte(s_tdata), .in_last(s_tlast), .out_valid(m_tvalid),
        .out_ready(m_tready), .out_idx(out_idx), .out_last(m_tlast),
        .cmd(cmd), .status(status)
    );

    sha2_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .mode(cfg_write ? pwdata[0] : mode_reg),
        .cmd(cmd), .status(status), .out_idx(out_idx), .out_word(out_word)
    );

endmodule
`default_nettype wire
